// ===== hdl/epcd_pkg.sv =====
// ----------------------------------------------------------------------------
// Echo pulse cliff detector package
// Shared types and constants: result record, phase codes, register indexes.
// ----------------------------------------------------------------------------
package epcd_pkg;

	// input operation codes
	localparam logic OP_START   = 1'b0;
	localparam logic OP_CAPTURE = 1'b1;

	// result kinds
	localparam logic KIND_TRIGGER = 1'b0;
	localparam logic KIND_MEASURE = 1'b1;

	// register indexes (byte address 4*i, index taken from paddr[2])
	localparam logic REG_LIMIT = 1'b0;
	localparam logic REG_TOP   = 1'b1;

	localparam int unsigned PADDR_W = 3;

	// field widths
	localparam int unsigned TICK_W  = 16;
	localparam int unsigned DIST_W  = 21;
	localparam int unsigned WRAP_W  = 33;

	// distance per tick in 0.001 cm
	localparam logic [DIST_W-1:0] TICKS_PER_UNIT = 21'd17;

	// cliff run length that raises the alarm
	localparam logic [1:0] RUN_ALARM = 2'd2;

	// register reset values
	localparam logic [DIST_W-1:0] LIMIT_RESET = 21'd20000;
	localparam logic [TICK_W-1:0] TOP_RESET   = 16'hFFFF;

	typedef enum logic [2:0] {
		PH_IDLE      = 3'b001,
		PH_WAIT_RISE = 3'b010,
		PH_WAIT_FALL = 3'b100
	} phase_t;

	typedef struct packed {
		logic              result_kind;
		logic [TICK_W-1:0] echo_ticks;
		logic [DIST_W-1:0] distance;
		logic              cliff_seen;
		logic              alarm;
	} res_t;

endpackage

// ===== hdl/echo_pulse_cliff_detector_core.sv =====
// ----------------------------------------------------------------------------
// Echo pulse cliff detector core
// Times an ultrasonic echo pulse from two captured timer edges, converts the
// width to distance and raises an alarm on repeated cliff readings.
//
//   Channel   Direction  Handshake           Payload
//   apb       in/out     psel/penable/pready paddr, pwdata, prdata
//   in        in         in_valid/in_ready   op, capture_value
//   out       out        out_valid/out_ready result_kind, echo_ticks, distance,
//                                            cliff_seen, alarm
//
// One input item is taken per cycle while in_ready is high; a result goes to
// the output register. A two-entry output stage (result register plus skid
// register) keeps input transfers flowing while one result waits.
// in_ready drops only while the skid register is occupied. Reset clears the
// phase, the cliff run and both output slots and reloads the config registers.
// ----------------------------------------------------------------------------
module echo_pulse_cliff_detector_core
	import epcd_pkg::*;
#(
	parameter int unsigned COUNT_BITS = 16
) (
	input  logic                 clk,
	input  logic                 arst_n,
	// configuration port
	input  logic                 psel,
	input  logic                 penable,
	input  logic                 pwrite,
	input  logic [PADDR_W-1:0]   paddr,
	input  logic [31:0]          pwdata,
	output logic [31:0]          prdata,
	output logic                 pready,
	// input items
	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic                 op,
	input  logic [TICK_W-1:0]    capture_value,
	// result items
	output logic                 out_valid,
	input  logic                 out_ready,
	output logic                 result_kind,
	output logic [TICK_W-1:0]    echo_ticks,
	output logic [DIST_W-1:0]    distance,
	output logic                 cliff_seen,
	output logic                 alarm
);

	// low COUNT_BITS bits of a capture, and the timer modulus mask
	localparam logic [TICK_W-1:0] CAP_MASK = (COUNT_BITS >= TICK_W) ? {TICK_W{1'b1}} :
		TICK_W'((33'd1 << COUNT_BITS) - 33'd1);
	localparam logic [WRAP_W-1:0] CNT_MASK = (33'd1 << COUNT_BITS) - 33'd1;

	logic [DIST_W-1:0] limit_q;
	logic [TICK_W-1:0] top_q;
	phase_t            phase_q;
	logic [TICK_W-1:0] rise_q;
	logic [1:0]        run_q;

	logic              out_valid_q;
	res_t              out_q;
	logic              skid_valid_q;
	res_t              skid_q;

	logic              cfg_wr;
	logic              accept;
	logic              pop;
	logic              has_res;
	logic [TICK_W-1:0] cap_m;
	logic [WRAP_W-1:0] wrap_sum;
	logic [WRAP_W-1:0] wrap_m;
	logic [TICK_W-1:0] width;
	logic [DIST_W-1:0] dist_calc;
	logic              cliff;
	logic [1:0]        run_next;
	phase_t            phase_next;
	res_t              res;

	// configuration access
	assign pready = 1'b1;
	assign cfg_wr = psel & penable & pwrite & pready;

	always_comb begin
		case (paddr[2])
			REG_LIMIT: prdata = {11'd0, limit_q};
			REG_TOP:   prdata = {16'd0, top_q};
			default:   prdata = 32'd0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_q <= LIMIT_RESET;
			top_q   <= TOP_RESET;
		end else if (cfg_wr) begin
			case (paddr[2])
				REG_LIMIT: limit_q <= pwdata[DIST_W-1:0];
				REG_TOP:   top_q   <= pwdata[TICK_W-1:0];
				default:   limit_q <= limit_q;
			endcase
		end
	end

	// handshake
	assign in_ready = ~skid_valid_q;
	assign accept   = in_valid & in_ready;
	assign pop      = out_valid_q & out_ready;

	// pulse width, wrapping over the timer period when the falling count is lower
	assign cap_m    = capture_value & CAP_MASK;
	assign wrap_sum = WRAP_W'(top_q) + WRAP_W'(1) + WRAP_W'(cap_m) - WRAP_W'(rise_q);
	assign wrap_m   = wrap_sum & CNT_MASK;

	always_comb begin
		if (cap_m >= rise_q) begin
			width = cap_m - rise_q;
		end else if (wrap_m > WRAP_W'({TICK_W{1'b1}})) begin
			width = {TICK_W{1'b1}};
		end else begin
			width = wrap_m[TICK_W-1:0];
		end
	end

	// distance and cliff decision
	assign dist_calc = DIST_W'(width) * TICKS_PER_UNIT;
	assign cliff     = (dist_calc >= limit_q) | (width == '0);

	always_comb begin
		if (!cliff) begin
			run_next = 2'd0;
		end else if (run_q < RUN_ALARM) begin
			run_next = run_q + 2'd1;
		end else begin
			run_next = run_q;
		end
	end

	// phase sequencing and result selection
	always_comb begin
		phase_next = phase_q;
		has_res    = 1'b0;
		res        = '0;
		case (phase_q)
			PH_IDLE: begin
				if (op == OP_START) begin
					phase_next      = PH_WAIT_RISE;
					has_res         = 1'b1;
					res.result_kind = KIND_TRIGGER;
				end
			end
			PH_WAIT_RISE: begin
				if (op == OP_CAPTURE) begin
					phase_next = PH_WAIT_FALL;
				end
			end
			PH_WAIT_FALL: begin
				if (op == OP_CAPTURE) begin
					phase_next      = PH_IDLE;
					has_res         = 1'b1;
					res.result_kind = KIND_MEASURE;
					res.echo_ticks  = width;
					res.distance    = dist_calc;
					res.cliff_seen  = cliff;
					res.alarm       = cliff & (run_next >= RUN_ALARM);
				end
			end
			default: begin
				phase_next = PH_IDLE;
			end
		endcase
	end

	// advance the measurement state on each input transfer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			rise_q  <= '0;
			run_q   <= 2'd0;
		end else if (accept) begin
			phase_q <= phase_next;
			if (phase_q == PH_WAIT_RISE && op == OP_CAPTURE) begin
				rise_q <= cap_m;
			end
			if (phase_q == PH_WAIT_FALL && op == OP_CAPTURE) begin
				run_q <= run_next;
			end
		end
	end

	// output register with skid slot
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (skid_valid_q) begin
			if (pop) begin
				out_valid_q  <= 1'b1;
				skid_valid_q <= 1'b0;
			end
		end else if (accept && has_res) begin
			if (!out_valid_q || pop) begin
				out_valid_q <= 1'b1;
			end else begin
				skid_valid_q <= 1'b1;
			end
		end else if (pop) begin
			out_valid_q <= 1'b0;
		end
	end

	// payload of the two slots, no reset needed
	always_ff @(posedge clk) begin
		if (skid_valid_q) begin
			if (pop) begin
				out_q <= skid_q;
			end
		end else if (accept && has_res) begin
			if (!out_valid_q || pop) begin
				out_q <= res;
			end else begin
				skid_q <= res;
			end
		end
	end

	assign out_valid   = out_valid_q;
	assign result_kind = out_q.result_kind;
	assign echo_ticks  = out_q.echo_ticks;
	assign distance    = out_q.distance;
	assign cliff_seen  = out_q.cliff_seen;
	assign alarm       = out_q.alarm;

`ifndef ASSERT_OFF
	// skid slot is only filled behind a full result register
	a_skid_order: assert property (@(posedge clk) disable iff (!arst_n)
		skid_valid_q |-> out_valid_q)
		else $error("skid slot holds a result while the result register is empty");

	// alarm only on a measured cliff reading
	a_alarm_cliff: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_q.alarm) |->
		(out_q.cliff_seen && out_q.result_kind == KIND_MEASURE))
		else $error("alarm raised without a measured cliff reading");

	// trigger results carry no measurement
	a_trigger_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_q.result_kind == KIND_TRIGGER) |->
		(out_q.echo_ticks == '0 && out_q.distance == '0 && !out_q.cliff_seen && !out_q.alarm))
		else $error("trigger result carries measurement fields");

	// cliff run saturates at the alarm count
	a_run_sat: assert property (@(posedge clk) disable iff (!arst_n)
		run_q <= RUN_ALARM)
		else $error("cliff run exceeded its saturation value");

	// a start transfer in idle arms the block
	a_start_arms: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && op == OP_START && phase_q == PH_IDLE) |=> (phase_q == PH_WAIT_RISE))
		else $error("start transfer in idle did not arm the block");
`endif

endmodule
